FILE: hw/rtl/id_table_adjacency_recorder_top_macros.svh
// Assertion macros shared by the id table adjacency recorder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ID_TABLE_ADJACENCY_RECORDER_TOP_MACROS_SVH
`define ID_TABLE_ADJACENCY_RECORDER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ITAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itar assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itar assertion failed");

`else

`define ITAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ITAR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/itar_pkg.sv
// Shared constants and types of the id table adjacency recorder.
// No dependencies; used by itar_id_table and the top level.
`timescale 1ns / 1ps

package itar_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 23;

    // Request into the id table: one edge to resolve.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] parent_id;
        logic [ID_W-1:0] child_id;
    } itar_req_t;

    // Resolution returned by the id table in the same cycle.
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] parent_slot;
        logic [IDX_W-1:0] child_slot;
        logic [CNT_W-1:0] count;
    } itar_res_t;

endpackage

FILE: hw/rtl/itar_id_table.sv
// Content-addressed id table: parallel lookup and append of parent and child ids.
// Depends on itar_pkg and id_table_adjacency_recorder_top_macros.svh.
`timescale 1ns / 1ps
`include "id_table_adjacency_recorder_top_macros.svh"

module itar_id_table (
    input  logic              clk,
    input  logic              rst_n,
    input  itar_pkg::itar_req_t req,
    output itar_pkg::itar_res_t res
);
    import itar_pkg::*;

    logic [ID_W-1:0]        store_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       count_mid;
    logic [TABLE_DEPTH-1:0] p_match;
    logic [TABLE_DEPTH-1:0] c_match;
    logic [IDX_W-1:0]       p_idx;
    logic [IDX_W-1:0]       c_idx;
    logic [IDX_W-1:0]       p_slot;
    logic [IDX_W-1:0]       c_slot;
    logic                   p_hit;
    logic                   p_ins;
    logic                   p_ok;
    logic                   c_same;
    logic                   c_hit;
    logic                   c_ins;
    logic                   full;
    logic                   c_full;

    // Compare every occupied slot against both ids at once.
    // Ids in the table are unique, so the match vectors are one-hot or empty.
    always_comb
    begin
        p_idx = '0;
        c_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            p_match[i] = (CNT_W'(i) < count_reg) && (store_reg[i] == req.parent_id);
            c_match[i] = (CNT_W'(i) < count_reg) && (store_reg[i] == req.child_id);
            p_idx      = p_idx | (p_match[i] ? IDX_W'(i) : '0);
            c_idx      = c_idx | (c_match[i] ? IDX_W'(i) : '0);
        end
    end

    // Parent first: hit, append at the next free slot, or overflow.
    // The child sees the parent's insertion, including the same id twice.
    always_comb
    begin
        full      = (count_reg == CNT_W'(TABLE_DEPTH));
        p_hit     = |p_match;
        p_ins     = !p_hit && !full;
        p_ok      = p_hit || !full;
        p_slot    = p_hit ? p_idx : count_reg[IDX_W-1:0];
        count_mid = count_reg + CNT_W'(p_ins);

        c_same    = p_ins && (req.child_id == req.parent_id);
        c_hit     = (|c_match) || c_same;
        c_full    = (count_mid == CNT_W'(TABLE_DEPTH));
        c_ins     = p_ok && !c_hit && !c_full;
        c_slot    = c_same ? p_slot : (c_hit ? c_idx : count_mid[IDX_W-1:0]);

        count_next      = req.valid ? (count_mid + CNT_W'(c_ins)) : count_reg;

        res.ok          = p_ok && (c_hit || !c_full);
        res.parent_slot = p_slot;
        res.child_slot  = c_slot;
        res.count       = count_mid + CNT_W'(c_ins);
    end

    // Fill count of the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Id storage; slots past the fill count are never compared.
    always_ff @(posedge clk)
    begin
        if (req.valid && p_ins)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= req.parent_id;
        end
        if (req.valid && c_ins)
        begin
            store_reg[count_mid[IDX_W-1:0]] <= req.child_id;
        end
    end

    // The count only moves on a request, and by at most two.
    `ITAR_ASSERT_NXT(a_count_idle, clk, rst_n, !req.valid, $stable(count_reg))
    `ITAR_ASSERT_NXT(a_count_step, clk, rst_n, req.valid,
        (count_reg - $past(count_reg)) <= CNT_W'(2))
    // A failed resolution leaves the table full.
    `ITAR_ASSERT_NXT(a_ovf_full, clk, rst_n, req.valid && !res.ok,
        count_reg == CNT_W'(TABLE_DEPTH))

endmodule

FILE: hw/rtl/id_table_adjacency_recorder_top.sv
// Top level of the id table adjacency recorder: request register, edge matrix, result register.
// Depends on itar_pkg, itar_id_table and id_table_adjacency_recorder_top_macros.svh.
//
//  Channel   Handshake         Payload
//  request   start / busy      parent_id, child_id
//  result    done (one cycle)  parent_index, child_index, overflow, entry_count
//
// A request is taken at every clock edge where start is high; busy is held low.
// Its result appears with done through the request register and the result register, one result per request, in order.
// The id table is updated at the edge that loads the result register, so a request
// taken in the next cycle already sees it.
// The matrix row is read at that same edge and written back from the edge write stage; a write
// still in flight to the same row is forwarded.
// Reset clears the fill count and the row valid flags, so each matrix row reads as zero
// until it is first written.
// The receiver cannot stall the result channel.
`timescale 1ns / 1ps
`include "id_table_adjacency_recorder_top_macros.svh"

module id_table_adjacency_recorder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [itar_pkg::ID_W-1:0]    parent_id,
    input  logic [itar_pkg::ID_W-1:0]    child_id,
    output logic                         done,
    output logic [itar_pkg::IDX_W-1:0]   parent_index,
    output logic [itar_pkg::IDX_W-1:0]   child_index,
    output logic                         overflow,
    output logic [itar_pkg::CNT_W-1:0]   entry_count
);
    import itar_pkg::*;

    logic                   req_valid_reg;
    logic [ID_W-1:0]        parent_id_reg;
    logic [ID_W-1:0]        child_id_reg;
    itar_req_t              req;
    itar_res_t              res;
    logic [TABLE_DEPTH-1:0] edge_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] row_valid_reg;
    logic                   wr_pending_reg;
    logic [IDX_W-1:0]       wr_row_reg;
    logic [IDX_W-1:0]       wr_col_reg;
    logic [TABLE_DEPTH-1:0] rd_row_reg;
    logic                   fwd_hit_reg;
    logic [TABLE_DEPTH-1:0] fwd_row_reg;
    logic [TABLE_DEPTH-1:0] row_base;
    logic [TABLE_DEPTH-1:0] row_new;
    logic                   done_reg;
    logic                   overflow_reg;
    logic [IDX_W-1:0]       parent_index_reg;
    logic [IDX_W-1:0]       child_index_reg;
    logic [CNT_W-1:0]       entry_count_reg;

    // Every request is taken; the pipeline never holds one off.
    assign busy = 1'b0;

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            parent_id_reg <= parent_id;
            child_id_reg  <= child_id;
        end
    end

    assign req.valid     = req_valid_reg;
    assign req.parent_id = parent_id_reg;
    assign req.child_id  = child_id_reg;

    // Lookup and insertion of both ids.
    itar_id_table u_id_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    // Edge write stage: a recorded edge is held in the write registers and written back to its row from them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pending_reg <= 1'b0;
        end
        else
        begin
            wr_pending_reg <= req.valid && res.ok;
        end
    end

    // Row and column of the edge, and whether the write ahead of it hits the same row.
    always_ff @(posedge clk)
    begin
        if (req.valid && res.ok)
        begin
            wr_row_reg  <= res.parent_slot;
            wr_col_reg  <= res.child_slot;
            fwd_hit_reg <= wr_pending_reg && (wr_row_reg == res.parent_slot);
            fwd_row_reg <= row_new;
        end
    end

    // Edge matrix memory: one row written and one row read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_pending_reg)
        begin
            edge_mem[wr_row_reg] <= row_new;
        end
        rd_row_reg <= edge_mem[res.parent_slot];
    end

    // Rows never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_pending_reg)
        begin
            row_valid_reg[wr_row_reg] <= 1'b1;
        end
    end

    // New row value: the current row with the child's column set.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            row_base = fwd_row_reg;
        end
        else if (row_valid_reg[wr_row_reg])
        begin
            row_base = rd_row_reg;
        end
        else
        begin
            row_base = '0;
        end
        row_new = row_base | (TABLE_DEPTH'(1) << wr_col_reg);
    end

    // Result register; indices read as zero on overflow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            overflow_reg     <= !res.ok;
            parent_index_reg <= res.ok ? res.parent_slot : '0;
            child_index_reg  <= res.ok ? res.child_slot : '0;
            entry_count_reg  <= res.count;
        end
    end

    assign done         = done_reg;
    assign overflow     = overflow_reg;
    assign parent_index = parent_index_reg;
    assign child_index  = child_index_reg;
    assign entry_count  = entry_count_reg;

    // A recorded edge is on its way to the matrix when its result is shown.
    `ITAR_ASSERT_IMP(a_edge_pend, clk, rst_n, done_reg && !overflow_reg,
        wr_pending_reg && (wr_row_reg == parent_index_reg) && (wr_col_reg == child_index_reg))
    // A written edge is present in the matrix after the write.
    `ITAR_ASSERT_NXT(a_edge_set, clk, rst_n, wr_pending_reg,
        row_valid_reg[$past(wr_row_reg)] && edge_mem[$past(wr_row_reg)][$past(wr_col_reg)])
    // Overflow results carry zero indices.
    `ITAR_ASSERT_IMP(a_ovf_zero, clk, rst_n, done_reg && overflow_reg,
        (parent_index_reg == '0) && (child_index_reg == '0))
    // Resolved slots lie below the reported count.
    `ITAR_ASSERT_IMP(a_slot_range, clk, rst_n, done_reg && !overflow_reg,
        (CNT_W'(parent_index_reg) < entry_count_reg)
        && (CNT_W'(child_index_reg) < entry_count_reg))

endmodule
